### rtl/bltu_pkg.sv
// Shared types, constants and decode functions for the byte-level token unmap block.
`timescale 1ns / 1ps
package bltu_pkg;

  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;
  localparam logic [9:0] MAP_HIGH_BASE = 10'd256;
  localparam logic [9:0] MAP_HIGH_TOP  = 10'd323;
  localparam logic [7:0] SOFT_HYPHEN   = 8'd173;
  localparam logic [7:0] SHIFT_UPPER   = 8'd94;

  typedef enum logic {
    ST_IDLE,
    ST_DECODE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic ready;
    logic take;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hold;
    logic slot_free;
    logic step_last;
  } status_t;

  // Sequence length from the lead byte; 0 for an invalid lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] l;
    if (!b[7])                              l = 3'd1;
    else if ((b & MASK_LEAD2) == CODE_LEAD2) l = 3'd2;
    else if ((b & MASK_LEAD3) == CODE_LEAD3) l = 3'd3;
    else if ((b & MASK_LEAD4) == CODE_LEAD4) l = 3'd4;
    else                                    l = 3'd0;
    return l;
  endfunction

  // Loose UTF-8 code point, continuation bits unchecked.
  function automatic logic [20:0] code_point(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] l);
    logic [20:0] cp;
    case (l)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  // Inverse byte-to-unicode map: {hit, byte}.
  function automatic logic [8:0] unmap_cp(input logic [20:0] cp);
    logic [9:0] c;
    logic [6:0] k;
    logic [8:0] r;
    c = cp[9:0];
    k = 7'(c - MAP_HIGH_BASE);
    r = 9'd0;
    if (cp[20:10] == 11'd0) begin
      if ((c >= 10'd33 && c <= 10'd126) || (c >= 10'd161 && c <= 10'd172) ||
          (c >= 10'd174 && c <= 10'd255)) begin
        r = {1'b1, c[7:0]};
      end else if (c >= MAP_HIGH_BASE && c <= MAP_HIGH_TOP) begin
        if (k <= 7'd32)      r = {1'b1, 1'b0, k};
        else if (k <= 7'd66) r = {1'b1, 8'({1'b0, k} + SHIFT_UPPER)};
        else                 r = {1'b1, SOFT_HYPHEN};
      end
    end
    return r;
  endfunction

endpackage

### rtl/bltu_in_if.sv
// Input channel: one vocabulary-string byte per transaction.
`timescale 1ns / 1ps
interface bltu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_token;

  modport source (output valid, output in_byte, output end_of_token, input ready);
  modport sink   (input valid, input in_byte, input end_of_token, output ready);
endinterface

### rtl/bltu_out_if.sv
// Output channel: one recovered raw byte per transaction.
`timescale 1ns / 1ps
interface bltu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       token_last;

  modport source (output valid, output out_byte, output run_last, output token_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input token_last,
                  output ready);
endinterface

### rtl/byte_level_token_unmap_core.sv
// Top level of the byte-level token unmap block: controller, datapath and channels.
// Flow: a byte that completes a sequence is taken in IDLE, then DECODE registers its
//   result bytes into the output register; no new byte is taken until the last one.
// Rate: held bytes are taken one per cycle; results of a completed byte come one per
//   cycle while the slot is free, from the single decode step and its map lookup.
// Reset (rst, synchronous): pending sequence dropped, output register empty.
`timescale 1ns / 1ps
module byte_level_token_unmap_core
  import bltu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  bltu_in_if.sink   in_ch,
  bltu_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  // Controller: IDLE takes one transaction; DECODE emits one byte per free slot.
  bltu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: holds an open multi-byte sequence and walks it on decode.
  bltu_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_byte      (in_ch.in_byte),
    .end_of_token (in_ch.end_of_token),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_byte     (out_ch.out_byte),
    .run_last     (out_ch.run_last),
    .token_last   (out_ch.token_last)
  );

  assign in_ch.ready = cmd.ready;

  // A string end never leaves bytes pending, so decode must follow.
  a_end_decodes: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.end_of_token |=> !in_ch.ready)
    else $error("token end did not start decode");

  // The last step of a run returns the block to taking input.
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.step_last |=> in_ch.ready)
    else $error("decode did not finish after last step");

  // An emitted byte appears as a valid output transaction.
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_ch.valid)
    else $error("emitted byte lost");

  // token_last only marks the final byte of a run.
  a_token_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.token_last |-> out_ch.run_last)
    else $error("token_last without run_last");

endmodule

### rtl/bltu_ctrl.sv
// Controller: accepts bytes and sequences the per-byte decode steps.
`timescale 1ns / 1ps
module bltu_ctrl
  import bltu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        cmd.take  = in_valid;
        if (in_valid && !status.hold) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.emit = status.slot_free;
        if (status.slot_free && status.step_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/bltu_dp.sv
// Datapath: byte buffer, decode position, map lookup and output register.
`timescale 1ns / 1ps
module bltu_dp
  import bltu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [7:0] in_byte,
  input  logic       end_of_token,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       token_last
);

  logic [7:0] seq [4];
  logic [1:0] count;      // pending bytes of an open sequence
  logic [2:0] len;        // bytes under decode
  logic [2:0] pos;
  logic [1:0] raw_left;   // raw bytes still owed by an unmapped sequence
  logic       end_flag;

  logic [7:0]  lead_src, b0, b1, b2, b3, dec_byte;
  logic [2:0]  lead_l, len_in, l, rem, adv, pos_next;
  logic [1:0]  p0, raw_left_next;
  logic [20:0] cp;
  logic [8:0]  m;

  always_comb begin
    // hold decision on the incoming byte
    lead_src    = (count == 2'd0) ? in_byte : seq[0];
    lead_l      = lead_len(lead_src);
    len_in      = {1'b0, count} + 3'd1;
    status.hold = !end_of_token && (lead_l != 3'd0) && (lead_l > len_in);

    // one output byte per step
    p0  = pos[1:0];
    b0  = seq[p0];
    b1  = seq[p0 + 2'd1];
    b2  = seq[p0 + 2'd2];
    b3  = seq[p0 + 2'd3];
    rem = len - pos;
    l   = lead_len(b0);
    cp  = code_point(b0, b1, b2, b3, l);
    m   = unmap_cp(cp);
    dec_byte      = b0;
    adv           = 3'd1;
    raw_left_next = 2'd0;
    if (raw_left != 2'd0) begin
      raw_left_next = raw_left - 2'd1;
    end else if (l != 3'd0 && l <= rem) begin
      if (m[8]) begin
        dec_byte = m[7:0];
        adv      = l;
      end else begin
        raw_left_next = 2'(l - 3'd1);
      end
    end
    pos_next         = pos + adv;
    status.step_last = (pos_next == len);
    status.slot_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) seq[count] <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 2'd0;
      len       <= 3'd0;
      pos       <= 3'd0;
      raw_left  <= 2'd0;
      end_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (status.hold) begin
          count <= count + 2'd1;
        end else begin
          count    <= 2'd0;
          len      <= len_in;
          pos      <= 3'd0;
          raw_left <= 2'd0;
          end_flag <= end_of_token;
        end
      end
      if (cmd.emit) begin
        pos       <= pos_next;
        raw_left  <= raw_left_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte   <= dec_byte;
      run_last   <= status.step_last;
      token_last <= status.step_last && end_flag;
    end
  end

endmodule
